// ===== design/hrgp_pkg.sv =====
package hrgp_pkg;

  localparam int MAX_STEPS = 4096;
  localparam int MIN_STEPS = 256;
  localparam int HALVINGS = 24;

  localparam int MAX_SHIFT = $clog2(MAX_STEPS);
  localparam int MIN_SHIFT = $clog2(MIN_STEPS);
  localparam int IDX_W = $clog2(MAX_STEPS + 1);
  localparam int CNT_W = $clog2(HALVINGS + 1);

  localparam int SQRT_ITERS = 32;
  localparam int DIV_ITERS = 46;
  localparam int ITER_W = 6;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_TERRAIN_PRESENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERRAIN_SPACING = 1'd1;
  localparam logic [CFG_DATA_W-1:0] SPACING_RESET = 31'd65536;

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_HIT   = 2'd1,
    KIND_MISS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SRC_QUERY = 2'd0,
    SRC_HITQ  = 2'd1,
    SRC_BEST  = 2'd2,
    SRC_MISS  = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    PT_ZERO   = 2'd0,
    PT_TRAVEL = 2'd1,
    PT_MARCH  = 2'd2,
    PT_MID    = 2'd3
  } ptsel_t;

  typedef struct packed {
    logic   load_start;
    logic   load_ans;
    logic   norm_step;
    logic   sq_acc;
    logic   sqrt_step;
    logic   div_load;
    logic   div_step;
    logic   div_store;
    logic   step_load;
    logic   ans_above;
    logic   advance;
    logic   bracket;
    logic   bisect_upd;
    logic   pt_load;
    logic   pt_mul;
    logic   pt_add;
    logic   out_load;
    logic [1:0] k;
    ptsel_t ptsel;
    src_t   src;
  } cmd_t;

  typedef struct packed {
    logic dir_zero;
    logic reach_bad;
    logic norm_right;
    logic norm_left;
    logic uz_zero;
    logic travel_ok;
    logic terrain;
    logic on;
    logic above;
    logic seen;
    logic t_ge_reach;
    logic idx_max;
    logic idx_zero;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/hrgp_req_if.sv =====
interface hrgp_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] reach;
  logic signed [31:0] surface_height;
  logic               on_terrain;

  modport source (
    output valid, req_type, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, reach,
    output surface_height, on_terrain,
    input  ready
  );
  modport sink (
    input  valid, req_type, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, reach,
    input  surface_height, on_terrain,
    output ready
  );
endinterface

// ===== design/hrgp_res_if.sv =====
interface hrgp_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (output valid, result_kind, point_x, point_y, input ready);
  modport sink (input valid, result_kind, point_x, point_y, output ready);
endinterface

// ===== design/hrgp_dp.sv =====
module hrgp_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  hrgp_pkg::cmd_t                    cmd,
  output hrgp_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [hrgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hrgp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [31:0]                origin_x,
  input  logic signed [31:0]                origin_y,
  input  logic signed [31:0]                origin_z,
  input  logic signed [31:0]                dir_x,
  input  logic signed [31:0]                dir_y,
  input  logic signed [31:0]                dir_z,
  input  logic signed [31:0]                reach_in,
  input  logic signed [31:0]                surface_height,
  input  logic                              on_terrain,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic signed [31:0]                out_x,
  output logic signed [31:0]                out_y
);

  logic                   terrain_present;
  logic [30:0]            terrain_spacing;
  logic signed [31:0]     start [3];
  logic [31:0]            mag [3];
  logic [2:0]             neg;
  logic signed [31:0]     reach;
  logic [14:0]            umag [3];
  logic [61:0]            sum;
  logic [63:0]            sq_res;
  logic [63:0]            sq_bit;
  logic [45:0]            dvd;
  logic [30:0]            rem;
  logic [30:0]            dvs;
  logic [30:0]            step;
  logic [30:0]            t;
  logic [30:0]            lo;
  logic [30:0]            hi;
  logic [30:0]            pt_t;
  logic [43:0]            raw;
  logic [hrgp_pkg::IDX_W-1:0] idx;
  logic                   seen;
  logic [hrgp_pkg::CNT_W-1:0] cnt;
  logic signed [31:0]     qx;
  logic signed [31:0]     qy;
  logic signed [31:0]     qz;
  logic signed [31:0]     bx;
  logic signed [31:0]     by;
  logic [45:0]            prod;
  logic                   psign;
  logic signed [31:0]     surf;
  logic                   on;

  logic [30:0]            len;
  logic [59:0]            sq_term;
  logic [63:0]            sq_trial;
  logic                   sq_ge;
  logic [31:0]            r2;
  logic                   dge;
  logic [30:0]            mid;
  logic [43:0]            raw_next;
  logic [30:0]            t_next;
  logic [30:0]            reach_u;
  logic [45:0]            rounded;
  logic [31:0]            rnd;
  logic signed [33:0]     rs;
  logic signed [31:0]     start_k;
  logic signed [33:0]     pt_sum;
  logic signed [31:0]     pt_sat;
  logic [31:0]            oz_abs;
  logic [30:0]            sp_half;
  logic [30:0]            rlo;
  logic [30:0]            rhi;
  logic [30:0]            st_lo;
  logic [30:0]            st_new;
  logic                   above;
  logic                   travel_neg;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  assign len = sq_res[30:0];
  assign sq_term = mag[cmd.k][29:0] * mag[cmd.k][29:0];
  assign sq_trial = sq_res + sq_bit;
  assign sq_ge = {2'b00, sum} >= sq_trial;
  assign r2 = {rem, dvd[45]};
  assign dge = r2 >= {1'b0, dvs};
  assign mid = 31'((32'(lo) + 32'(hi)) >> 1);
  assign reach_u = reach[30:0];
  assign raw_next = raw + 44'(step);
  assign t_next = (raw_next > 44'(reach_u)) ? reach_u : raw_next[30:0];
  assign rounded = prod + 46'd8192;
  assign rnd = rounded[45:14];
  assign rs = psign ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
  assign start_k = start[cmd.k];
  assign pt_sum = {{2{start_k[31]}}, start_k} + rs;
  assign pt_sat = (pt_sum[33:31] == 3'b000 || pt_sum[33:31] == 3'b111) ? pt_sum[31:0] :
                  (pt_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  assign oz_abs = abs32(start[2]);
  assign sp_half = {1'b0, terrain_spacing[30:1]};
  assign rlo = reach_u >> hrgp_pkg::MAX_SHIFT;
  assign rhi = reach_u >> hrgp_pkg::MIN_SHIFT;
  assign st_lo = (sp_half < rlo) ? rlo : sp_half;
  assign st_new = (st_lo > rhi) ? rhi : st_lo;
  assign above = qz > surf;
  assign travel_neg = (dvd != 46'd0) && (!start[2][31] != neg[2]);

  always_comb begin
    sts.dir_zero   = (mag[0] == 32'd0) && (mag[1] == 32'd0) && (mag[2] == 32'd0);
    sts.reach_bad  = reach[31] || (reach == 32'sd0);
    sts.norm_right = |{mag[0][31:30], mag[1][31:30], mag[2][31:30]};
    sts.norm_left  = !(|{mag[0][31:29], mag[1][31:29], mag[2][31:29]});
    sts.uz_zero    = umag[2] == 15'd0;
    sts.travel_ok  = !travel_neg && (dvd[45:31] == 15'd0) && (dvd[30:0] <= reach_u);
    sts.terrain    = terrain_present;
    sts.on         = on;
    sts.above      = above;
    sts.seen       = seen;
    sts.t_ge_reach = t >= reach_u;
    sts.idx_max    = idx == hrgp_pkg::IDX_W'(hrgp_pkg::MAX_STEPS);
    sts.idx_zero   = idx == '0;
    sts.cnt_last   = cnt >= hrgp_pkg::CNT_W'(hrgp_pkg::HALVINGS - 1);
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      terrain_present <= 1'b0;
      terrain_spacing <= hrgp_pkg::SPACING_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == hrgp_pkg::REG_TERRAIN_PRESENT) begin
        terrain_present <= cfg_data[0];
      end
      if (cfg_we && cfg_index == hrgp_pkg::REG_TERRAIN_SPACING) begin
        terrain_spacing <= cfg_data;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      start[0] <= origin_x;
      start[1] <= origin_y;
      start[2] <= origin_z;
      mag[0] <= abs32(dir_x);
      mag[1] <= abs32(dir_y);
      mag[2] <= abs32(dir_z);
      neg <= {dir_z[31], dir_y[31], dir_x[31]};
      reach <= reach_in;
      sum <= '0;
      sq_res <= '0;
      sq_bit <= 64'd1 << 62;
      idx <= '0;
      seen <= 1'b0;
      cnt <= '0;
      raw <= '0;
      t <= '0;
    end
    if (cmd.load_ans) begin
      surf <= surface_height;
      on <= on_terrain;
    end
    if (cmd.norm_step) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= sts.norm_right ? (mag[i] >> 1) : (mag[i] << 1);
      end
    end
    if (cmd.sq_acc) begin
      sum <= sum + 62'(sq_term);
    end
    if (cmd.sqrt_step) begin
      if (sq_ge) begin
        sum <= 62'({2'b00, sum} - sq_trial);
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.div_load) begin
      rem <= '0;
      if (cmd.k == 2'd3) begin
        dvd <= {oz_abs, 14'd0};
        dvs <= 31'(umag[2]);
      end else begin
        dvd <= 46'({mag[cmd.k][29:0], 14'd0}) + 46'(len[30:1]);
        dvs <= len;
      end
    end
    if (cmd.div_step) begin
      rem <= dge ? 31'(r2 - {1'b0, dvs}) : r2[30:0];
      dvd <= {dvd[44:0], dge};
    end
    if (cmd.div_store) begin
      umag[cmd.k] <= dvd[14:0];
    end
    if (cmd.step_load) begin
      step <= st_new;
    end
    if (cmd.ans_above) begin
      lo <= t;
      seen <= 1'b1;
    end
    if (cmd.advance) begin
      idx <= idx + 1'b1;
      raw <= raw_next;
      t <= t_next;
    end
    if (cmd.bracket) begin
      hi <= t;
      bx <= qx;
      by <= qy;
      cnt <= '0;
    end
    if (cmd.bisect_upd) begin
      if (above) begin
        lo <= mid;
      end else begin
        hi <= mid;
        bx <= qx;
        by <= qy;
      end
      cnt <= cnt + 1'b1;
    end
    if (cmd.pt_load) begin
      case (cmd.ptsel)
        hrgp_pkg::PT_ZERO:   pt_t <= '0;
        hrgp_pkg::PT_TRAVEL: pt_t <= dvd[30:0];
        hrgp_pkg::PT_MARCH:  pt_t <= t;
        hrgp_pkg::PT_MID:    pt_t <= mid;
        default:             pt_t <= '0;
      endcase
    end
    if (cmd.pt_mul) begin
      prod <= umag[cmd.k] * pt_t;
      psign <= neg[cmd.k];
    end
    if (cmd.pt_add) begin
      case (cmd.k)
        2'd0:    qx <= pt_sat;
        2'd1:    qy <= pt_sat;
        default: qz <= pt_sat;
      endcase
    end
    if (cmd.out_load) begin
      case (cmd.src)
        hrgp_pkg::SRC_QUERY: begin
          out_kind <= hrgp_pkg::KIND_QUERY;
          out_x <= qx;
          out_y <= qy;
        end
        hrgp_pkg::SRC_HITQ: begin
          out_kind <= hrgp_pkg::KIND_HIT;
          out_x <= qx;
          out_y <= qy;
        end
        hrgp_pkg::SRC_BEST: begin
          out_kind <= hrgp_pkg::KIND_HIT;
          out_x <= bx;
          out_y <= by;
        end
        default: begin
          out_kind <= hrgp_pkg::KIND_MISS;
          out_x <= '0;
          out_y <= '0;
        end
      endcase
    end
  end

endmodule

// ===== design/hrgp_ctrl.sv =====
module hrgp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_req_type,
  output logic           in_ready,
  input  hrgp_pkg::sts_t sts,
  output hrgp_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CHK    = 13'b0000000000010,
    S_NORM   = 13'b0000000000100,
    S_SQ     = 13'b0000000001000,
    S_SQRT   = 13'b0000000010000,
    S_DLOAD  = 13'b0000000100000,
    S_DIV    = 13'b0000001000000,
    S_DSTORE = 13'b0000010000000,
    S_MODE   = 13'b0000100000000,
    S_PLANE  = 13'b0001000000000,
    S_PT     = 13'b0010000000000,
    S_EMIT   = 13'b0100000000000,
    S_ANS    = 13'b1000000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_MARCH  = 3'b010,
    PH_BISECT = 3'b100
  } phase_t;

  state_t                         state, state_next;
  phase_t                         phase, phase_next;
  logic [hrgp_pkg::ITER_W-1:0]    iter, iter_next;
  logic [1:0]                     dk, dk_next;
  hrgp_pkg::src_t                 src, src_next;
  hrgp_pkg::ptsel_t               ptsel, ptsel_next;
  logic [hrgp_pkg::ITER_W-1:0]    im1;

  assign im1 = iter - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
      iter <= '0;
      dk <= '0;
      src <= hrgp_pkg::SRC_MISS;
      ptsel <= hrgp_pkg::PT_ZERO;
    end else begin
      state <= state_next;
      phase <= phase_next;
      iter <= iter_next;
      dk <= dk_next;
      src <= src_next;
      ptsel <= ptsel_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    iter_next = iter;
    dk_next = dk;
    src_next = src;
    ptsel_next = ptsel;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_req_type) begin
            cmd.load_start = 1'b1;
            phase_next = PH_IDLE;
            state_next = S_CHK;
          end else if (phase != PH_IDLE) begin
            cmd.load_ans = 1'b1;
            state_next = S_ANS;
          end
        end
      end
      S_CHK: begin
        if (sts.dir_zero || sts.reach_bad) begin
          src_next = hrgp_pkg::SRC_MISS;
          state_next = S_EMIT;
        end else begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_right || sts.norm_left) begin
          cmd.norm_step = 1'b1;
        end else begin
          iter_next = '0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_acc = 1'b1;
        cmd.k = iter[1:0];
        iter_next = iter + 1'b1;
        if (iter == hrgp_pkg::ITER_W'(2)) begin
          iter_next = '0;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_next = iter + 1'b1;
        if (iter == hrgp_pkg::ITER_W'(hrgp_pkg::SQRT_ITERS - 1)) begin
          dk_next = 2'd0;
          state_next = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cmd.k = dk;
        iter_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        iter_next = iter + 1'b1;
        if (iter == hrgp_pkg::ITER_W'(hrgp_pkg::DIV_ITERS - 1)) begin
          state_next = (dk == 2'd3) ? S_PLANE : S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        cmd.k = dk;
        if (dk == 2'd2) begin
          state_next = S_MODE;
        end else begin
          dk_next = dk + 1'b1;
          state_next = S_DLOAD;
        end
      end
      S_MODE: begin
        if (sts.terrain) begin
          cmd.step_load = 1'b1;
          phase_next = PH_MARCH;
          ptsel_next = hrgp_pkg::PT_ZERO;
          src_next = hrgp_pkg::SRC_QUERY;
          iter_next = '0;
          state_next = S_PT;
        end else if (sts.uz_zero) begin
          src_next = hrgp_pkg::SRC_MISS;
          state_next = S_EMIT;
        end else begin
          dk_next = 2'd3;
          state_next = S_DLOAD;
        end
      end
      S_PLANE: begin
        if (sts.travel_ok) begin
          ptsel_next = hrgp_pkg::PT_TRAVEL;
          src_next = hrgp_pkg::SRC_HITQ;
          iter_next = '0;
          state_next = S_PT;
        end else begin
          src_next = hrgp_pkg::SRC_MISS;
          state_next = S_EMIT;
        end
      end
      S_PT: begin
        cmd.ptsel = ptsel;
        cmd.k = im1[2:1];
        iter_next = iter + 1'b1;
        if (iter == '0) begin
          cmd.pt_load = 1'b1;
        end else if (!im1[0]) begin
          cmd.pt_mul = 1'b1;
        end else begin
          cmd.pt_add = 1'b1;
        end
        if (iter == hrgp_pkg::ITER_W'(6)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.src = src;
          if (src != hrgp_pkg::SRC_QUERY) begin
            phase_next = PH_IDLE;
          end
          state_next = S_IDLE;
        end
      end
      S_ANS: begin
        iter_next = '0;
        if (phase == PH_MARCH) begin
          if (sts.on && !sts.above && sts.seen) begin
            cmd.bracket = 1'b1;
            phase_next = PH_BISECT;
            ptsel_next = hrgp_pkg::PT_MID;
            src_next = hrgp_pkg::SRC_QUERY;
            state_next = S_PT;
          end else if (sts.on && !sts.above) begin
            src_next = sts.idx_zero ? hrgp_pkg::SRC_MISS : hrgp_pkg::SRC_HITQ;
            state_next = S_EMIT;
          end else begin
            cmd.ans_above = sts.on;
            if (sts.t_ge_reach || sts.idx_max) begin
              src_next = hrgp_pkg::SRC_MISS;
              state_next = S_EMIT;
            end else begin
              cmd.advance = 1'b1;
              ptsel_next = hrgp_pkg::PT_MARCH;
              src_next = hrgp_pkg::SRC_QUERY;
              state_next = S_PT;
            end
          end
        end else begin
          if (!sts.on) begin
            src_next = hrgp_pkg::SRC_BEST;
            state_next = S_EMIT;
          end else begin
            cmd.bisect_upd = 1'b1;
            if (sts.cnt_last) begin
              src_next = hrgp_pkg::SRC_BEST;
              state_next = S_EMIT;
            end else begin
              ptsel_next = hrgp_pkg::PT_MID;
              src_next = hrgp_pkg::SRC_QUERY;
              state_next = S_PT;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/heightfield_ray_ground_pick.sv =====
// Finds where a ray first meets the ground. A start request with a nonzero
// direction and a positive reach aligns the direction by shifts and normalizes
// it with a bit-serial square root and three shift-subtract divisions, then
// either answers at once for the flat plane (after one more division when the
// unit z component is nonzero) or issues the first elevation query; other start
// requests are answered with a miss. Each elevation answer produces the next
// query, hit or miss, using the shared multiplier that evaluates the three point
// components one after another. One request is worked on at a time; a finished
// result waits in the output register while the next request is taken.
module heightfield_ray_ground_pick (
  input  logic                            clk,
  input  logic                            rst,
  hrgp_req_if.sink                        req,
  hrgp_res_if.source                      res,
  input  logic                            cfg_we,
  input  logic [hrgp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrgp_pkg::CFG_DATA_W-1:0] cfg_data
);

  hrgp_pkg::cmd_t cmd;
  hrgp_pkg::sts_t sts;

  hrgp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_req_type(req.req_type),
    .in_ready   (req.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hrgp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .origin_x      (req.origin_x),
    .origin_y      (req.origin_y),
    .origin_z      (req.origin_z),
    .dir_x         (req.dir_x),
    .dir_y         (req.dir_y),
    .dir_z         (req.dir_z),
    .reach_in      (req.reach),
    .surface_height(req.surface_height),
    .on_terrain    (req.on_terrain),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .out_kind      (res.result_kind),
    .out_x         (res.point_x),
    .out_y         (res.point_y)
  );

endmodule

// ===== design/hrgp_check.sv =====
module hrgp_check (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_type,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  result_kind,
  input logic [31:0] point_x,
  input logic [31:0] point_y
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(result_kind) &&
      $stable(point_x) && $stable(point_y))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && result_kind == hrgp_pkg::KIND_MISS |-> point_x == 32'd0 && point_y == 32'd0)
    else $error("miss with nonzero point");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_type |=> !req_ready)
    else $error("ready right after a start request");

endmodule

bind heightfield_ray_ground_pick hrgp_check u_check (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_type   (req.req_type),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .result_kind(res.result_kind),
  .point_x    (res.point_x),
  .point_y    (res.point_y)
);

// ===== tb/heightfield_ray_ground_pick_test.sv =====
module heightfield_ray_ground_pick_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    RAY_IDLE   = 2'd0,
    RAY_MARCH  = 2'd1,
    RAY_BISECT = 2'd2
  } ray_phase_t;

  localparam bit REQ_START = 1'b0;
  localparam bit REQ_ANSWER = 1'b1;
  localparam int I32_HI = 32'h7fff_ffff;
  localparam int I32_LO = int'(32'h8000_0000);
  localparam int ONE = 65536;
  localparam int SETTLE = 300;
  localparam int SHOW_LIMIT = 40;
  localparam longint CYCLE_LIMIT = 6_000_000;

  typedef struct {
    bit rtype;
    int ox, oy, oz, dx, dy, dz, rch, surf;
    bit on;
  } pick_req_t;

  typedef struct {
    hrgp_pkg::kind_t kind;
    int    px, py;
  } pick_res_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [hrgp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hrgp_pkg::CFG_DATA_W-1:0] cfg_data;

  hrgp_req_if req();
  hrgp_res_if res();

  heightfield_ray_ground_pick dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predicted block state.
  bit         terrain_on;
  bit [30:0]  spacing;
  longint     org[3];
  longint     udir[3];
  longint     ray_len, step_len, lo_t, hi_t, probe_z, best_x, best_y;
  int unsigned step_no, halvings;
  bit         was_above;
  ray_phase_t ray_phase;

  pick_res_t pick_q[$];
  pick_res_t due;
  int  errors, items, results, hits, misses;
  longint cycles;
  bit  quiet;
  int  ready_hold;
  int  ready_stall;

  function automatic longint clip32(longint v);
    if (v > longint'(I32_HI)) return longint'(I32_HI);
    if (v < longint'(I32_LO)) return longint'(I32_LO);
    return v;
  endfunction

  function automatic longint along_dir(longint u, longint t);
    longint unsigned m;
    longint r;
    m = (u < 0 ? -u : u) * t;
    r = longint'((m + 64'd8192) >> 14);
    return u < 0 ? -r : r;
  endfunction

  function automatic void point_at_travel(input longint t, output longint px, py, pz);
    px = clip32(org[0] + along_dir(udir[0], t));
    py = clip32(org[1] + along_dir(udir[1], t));
    pz = clip32(org[2] + along_dir(udir[2], t));
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned acc, b;
    acc = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= acc + b) begin
        v = v - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc >>= 1;
      end
      b >>= 2;
    end
    return acc;
  endfunction

  function automatic void set_unit_dir(longint cx, longint cy, longint cz);
    longint c[3];
    longint unsigned mag[3];
    longint unsigned top, sum, len;
    longint u;
    c[0] = cx;
    c[1] = cy;
    c[2] = cz;
    top = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = c[k] < 0 ? -c[k] : c[k];
      if (mag[k] > top) top = mag[k];
    end
    while (top < (64'd1 << 29)) begin
      top <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    while (top >= (64'd1 << 30)) begin
      top >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    sum = 0;
    for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
    len = root64(sum);
    for (int k = 0; k < 3; k++) begin
      u = longint'(((mag[k] << 14) + len / 2) / len);
      udir[k] = c[k] < 0 ? -u : u;
    end
  endfunction

  function automatic pick_res_t emit_probe(longint t);
    longint px, py, pz;
    pick_res_t o;
    point_at_travel(t, px, py, pz);
    probe_z = pz;
    o.kind = hrgp_pkg::KIND_QUERY;
    o.px = int'(px);
    o.py = int'(py);
    return o;
  endfunction

  function automatic pick_res_t close_ray(hrgp_pkg::kind_t k, longint x, longint y);
    pick_res_t o;
    ray_phase = RAY_IDLE;
    o.kind = k;
    o.px = (k == hrgp_pkg::KIND_MISS) ? 0 : int'(x);
    o.py = (k == hrgp_pkg::KIND_MISS) ? 0 : int'(y);
    return o;
  endfunction

  function automatic longint march_travel();
    longint t;
    t = longint'(step_no) * step_len;
    return t > ray_len ? ray_len : t;
  endfunction

  // Returns 1 when the request produces a result.
  function automatic bit predict_pick(input pick_req_t r, output pick_res_t o);
    longint t, mid, surf, px, py, pz, st, travel;
    if (r.rtype == REQ_START) begin
      ray_phase = RAY_IDLE;
      was_above = 0;
      halvings = 0;
      step_no = 0;
      if ((r.dx == 0 && r.dy == 0 && r.dz == 0) || r.rch <= 0) begin
        o = close_ray(hrgp_pkg::KIND_MISS, 0, 0);
        return 1;
      end
      org[0] = r.ox;
      org[1] = r.oy;
      org[2] = r.oz;
      ray_len = r.rch;
      set_unit_dir(r.dx, r.dy, r.dz);
      if (!terrain_on) begin
        if (udir[2] == 0) begin
          o = close_ray(hrgp_pkg::KIND_MISS, 0, 0);
          return 1;
        end
        travel = (-org[2] * 16384) / udir[2];
        if (travel < 0 || travel > ray_len) begin
          o = close_ray(hrgp_pkg::KIND_MISS, 0, 0);
          return 1;
        end
        point_at_travel(travel, px, py, pz);
        o = close_ray(hrgp_pkg::KIND_HIT, px, py);
        return 1;
      end
      st = longint'(spacing >> 1);
      if (st < ray_len / hrgp_pkg::MAX_STEPS) st = ray_len / hrgp_pkg::MAX_STEPS;
      if (st > ray_len / hrgp_pkg::MIN_STEPS) st = ray_len / hrgp_pkg::MIN_STEPS;
      step_len = st;
      ray_phase = RAY_MARCH;
      o = emit_probe(0);
      return 1;
    end
    surf = r.surf;
    if (ray_phase == RAY_MARCH) begin
      t = march_travel();
      if (r.on) begin
        point_at_travel(t, px, py, pz);
        if (probe_z - surf > 0) begin
          lo_t = t;
          was_above = 1;
        end else if (was_above) begin
          hi_t = t;
          best_x = px;
          best_y = py;
          halvings = 0;
          ray_phase = RAY_BISECT;
          o = emit_probe((lo_t + hi_t) / 2);
          return 1;
        end else if (step_no == 0) begin
          o = close_ray(hrgp_pkg::KIND_MISS, 0, 0);
          return 1;
        end else begin
          o = close_ray(hrgp_pkg::KIND_HIT, px, py);
          return 1;
        end
      end
      if (t >= ray_len) begin
        o = close_ray(hrgp_pkg::KIND_MISS, 0, 0);
        return 1;
      end
      step_no++;
      if (step_no > hrgp_pkg::MAX_STEPS) begin
        o = close_ray(hrgp_pkg::KIND_MISS, 0, 0);
        return 1;
      end
      o = emit_probe(march_travel());
      return 1;
    end
    if (ray_phase == RAY_BISECT) begin
      mid = (lo_t + hi_t) / 2;
      if (!r.on) begin
        o = close_ray(hrgp_pkg::KIND_HIT, best_x, best_y);
        return 1;
      end
      if (probe_z - surf > 0) begin
        lo_t = mid;
      end else begin
        hi_t = mid;
        point_at_travel(mid, px, py, pz);
        best_x = px;
        best_y = py;
      end
      halvings++;
      if (halvings >= hrgp_pkg::HALVINGS) begin
        o = close_ray(hrgp_pkg::KIND_HIT, best_x, best_y);
        return 1;
      end
      o = emit_probe((lo_t + hi_t) / 2);
      return 1;
    end
    return 0;
  endfunction

  function automatic pick_req_t start_req(int ox, oy, oz, dx, dy, dz, rch);
    pick_req_t r;
    r.rtype = REQ_START;
    r.ox = ox;
    r.oy = oy;
    r.oz = oz;
    r.dx = dx;
    r.dy = dy;
    r.dz = dz;
    r.rch = rch;
    r.surf = $urandom;
    r.on = 1'($urandom);
    return r;
  endfunction

  function automatic pick_req_t answer_req(longint h, bit on);
    pick_req_t r;
    r.rtype = REQ_ANSWER;
    r.ox = $urandom;
    r.oy = $urandom;
    r.oz = $urandom;
    r.dx = $urandom;
    r.dy = $urandom;
    r.dz = $urandom;
    r.rch = $urandom;
    r.surf = int'(clip32(h));
    r.on = on;
    return r;
  endfunction

  function automatic int pick_gap();
    int x;
    if (quiet) return 0;
    x = $urandom_range(99);
    if (x < 60) return 0;
    if (x < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= SHOW_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  task automatic send_request(pick_req_t r);
    int gap;
    pick_res_t o;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.req_type <= r.rtype;
    req.origin_x <= r.ox;
    req.origin_y <= r.oy;
    req.origin_z <= r.oz;
    req.dir_x <= r.dx;
    req.dir_y <= r.dy;
    req.dir_z <= r.dz;
    req.reach <= r.rch;
    req.surface_height <= r.surf;
    req.on_terrain <= r.on;
    do @(posedge clk); while (!req.ready);
    items++;
    if (predict_pick(r, o)) pick_q.push_back(o);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pick_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [hrgp_pkg::CFG_IDX_W-1:0] idx,
                           logic [hrgp_pkg::CFG_DATA_W-1:0] data);
    if (ray_phase != RAY_IDLE) send_request(start_req(1, 2, 3, 0, 0, 0, ONE));
    wait_results_done();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == hrgp_pkg::REG_TERRAIN_PRESENT) terrain_on = data[0];
    else spacing = data;
  endtask

  // Answers the ray's queries against a level ground, roughened when rough is set, until it ends or the limit is hit.
  task automatic run_ray(pick_req_t s, longint ground, int off_pct, int limit, bit rough);
    int n;
    longint h;
    send_request(s);
    n = 0;
    while (ray_phase != RAY_IDLE && n < limit) begin
      h = ground;
      if (rough) begin
        if ($urandom_range(9) == 0) h = int'($urandom);
        else h = ground + longint'($urandom_range(0, 131072)) - 65536;
      end
      send_request(answer_req(h, $urandom_range(99) >= off_pct));
      n++;
    end
  endtask

  task automatic test_plane_ground();
    send_request(answer_req(5 * ONE, 1));
    send_request(start_req(ONE, ONE, ONE, 0, 0, 0, 10 * ONE));
    send_request(start_req(0, 0, 10 * ONE, 0, 0, -ONE, 0));
    send_request(start_req(0, 0, 10 * ONE, 0, 0, -ONE, I32_LO));
    send_request(start_req(3 * ONE, -2 * ONE, 10 * ONE, ONE, ONE, -ONE, 100 * ONE));
    send_request(start_req(0, 0, 10 * ONE, ONE, ONE, 0, 100 * ONE));
    send_request(start_req(0, 0, 10 * ONE, 0, ONE, ONE, 100 * ONE));
    send_request(start_req(0, 0, 10 * ONE, 0, 0, -ONE, ONE));
    send_request(start_req(I32_HI, I32_LO, I32_LO, I32_LO, I32_HI, I32_HI, I32_HI));
    send_request(start_req(I32_LO, I32_HI, I32_HI, I32_HI, I32_LO, I32_LO, I32_HI));
    send_request(start_req(0, 0, -5 * ONE, 1, -1, 1, I32_HI));
  endtask

  task automatic test_terrain_cases();
    write_reg(hrgp_pkg::REG_TERRAIN_PRESENT, 31'd1);
    run_ray(start_req(0, 0, 10 * ONE, ONE, 0, -ONE, 100 * ONE), 0, 0, 100, 0);
    run_ray(start_req(0, 0, 10 * ONE, ONE, 0, -ONE, 100 * ONE), 20 * ONE, 0, 10, 0);
    send_request(start_req(0, 0, 10 * ONE, ONE, ONE, -ONE, 100 * ONE));
    send_request(answer_req(0, 0));
    send_request(answer_req(20 * ONE, 1));
    send_request(start_req(ONE, -ONE, 10 * ONE, 0, ONE, -ONE, 100 * ONE));
    while (ray_phase == RAY_MARCH) send_request(answer_req(0, 1));
    repeat (3) send_request(answer_req(0, 1));
    send_request(answer_req(0, 0));
    send_request(start_req(0, 0, 0, ONE, 0, -ONE, 100 * ONE));
    send_request(answer_req(I32_LO, 1));
    send_request(answer_req(I32_HI, 1));
    run_ray(start_req(0, 0, 10 * ONE, -ONE, ONE, -ONE, 100 * ONE), 0, 30, 4, 0);
    run_ray(start_req(0, 0, 10 * ONE, -ONE, -ONE, -2 * ONE, 50 * ONE), ONE, 20, 100, 1);
  endtask

  task automatic test_march_limits();
    write_reg(hrgp_pkg::REG_TERRAIN_SPACING, 31'd0);
    send_request(start_req(0, 0, 0, ONE, 0, -ONE, 200));
    repeat (3) send_request(answer_req(I32_LO, 1));
    run_ray(start_req(0, 0, 0, ONE, 0, -ONE, 200), I32_LO, 5, 40, 0);
    write_reg(hrgp_pkg::REG_TERRAIN_SPACING, 31'h7fff_ffff);
    run_ray(start_req(0, 0, 0, ONE, ONE, ONE, 300), I32_LO, 5, 40, 0);
    write_reg(hrgp_pkg::REG_TERRAIN_SPACING, hrgp_pkg::SPACING_RESET);
  endtask

  task automatic test_output_pressure();
    write_reg(hrgp_pkg::REG_TERRAIN_PRESENT, 31'd1);
    quiet = 1;
    ready_hold = 400;
    run_ray(start_req(0, 0, 20 * ONE, ONE, ONE, -ONE, 100 * ONE), 0, 0, 60, 0);
    wait_results_done();
    run_ray(start_req(0, 0, 20 * ONE, -ONE, 0, -ONE, 100 * ONE), 0, 0, 100, 0);
    quiet = 0;
  endtask

  task automatic test_random_rays();
    int stop_at, x;
    longint g, height;
    pick_req_t s;
    stop_at = items + 200;
    while (items < stop_at) begin
      quiet = ($urandom_range(9) == 0);
      x = $urandom_range(99);
      if (x < 4) begin
        if ($urandom_range(1) == 0) begin
          write_reg(hrgp_pkg::REG_TERRAIN_PRESENT, 31'($urandom_range(3) != 0));
        end else begin
          case ($urandom_range(5))
            0: write_reg(hrgp_pkg::REG_TERRAIN_SPACING, 31'd0);
            1: write_reg(hrgp_pkg::REG_TERRAIN_SPACING, 31'd1);
            2: write_reg(hrgp_pkg::REG_TERRAIN_SPACING, 31'h7fff_ffff);
            3: write_reg(hrgp_pkg::REG_TERRAIN_SPACING, 31'd1 << 20);
            4: write_reg(hrgp_pkg::REG_TERRAIN_SPACING, hrgp_pkg::SPACING_RESET);
            default: write_reg(hrgp_pkg::REG_TERRAIN_SPACING, 31'($urandom));
          endcase
        end
      end else if (x < 10) begin
        s = answer_req(int'($urandom), 1'($urandom));
        s.rtype = 1'($urandom);
        send_request(s);
      end else if (x < 16) begin
        s = start_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_ray(s, int'($urandom), 10, 20, 1);
      end else begin
        g = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
        height = $urandom_range(1, 1 << 22);
        s = start_req($urandom_range(0, 1 << 25), $urandom, int'(clip32(g + height)),
                      int'($urandom_range(0, 1 << 21)) - (1 << 20),
                      int'($urandom_range(0, 1 << 21)) - (1 << 20),
                      -int'($urandom_range(1, 1 << 20)), $urandom_range(1 << 16, 1 << 26));
        if ($urandom_range(1) == 0) s.ox = -s.ox;
        if ($urandom_range(9) == 0) s.dz = -s.dz;
        run_ray(s, g, $urandom_range(0, 20), $urandom_range(40, 300), $urandom_range(3) == 0);
      end
    end
    quiet = 0;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
               pick_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    res.ready = 1'b0;
    ready_stall = 0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
        res.ready <= 1'b0;
      end else if (ready_stall > 0) begin
        ready_stall--;
        res.ready <= 1'b0;
      end else if (quiet || $urandom_range(99) < 70) begin
        res.ready <= 1'b1;
      end else begin
        ready_stall = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        res.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      results++;
      if (pick_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d at (%0d,%0d)",
                                  res.result_kind, res.point_x, res.point_y));
      end else begin
        due = pick_q.pop_front();
        if (due.kind == hrgp_pkg::KIND_HIT) hits++;
        if (due.kind == hrgp_pkg::KIND_MISS) misses++;
        if (res.result_kind !== due.kind)
          report_mismatch($sformatf("result %0d kind %0d, predicted %0d", results,
                                    res.result_kind, due.kind));
        if (res.point_x !== due.px)
          report_mismatch($sformatf("result %0d x %0d, predicted %0d", results,
                                    res.point_x, due.px));
        if (res.point_y !== due.py)
          report_mismatch($sformatf("result %0d y %0d, predicted %0d", results,
                                    res.point_y, due.py));
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.origin_x = 0;
    req.origin_y = 0;
    req.origin_z = 0;
    req.dir_x = 0;
    req.dir_y = 0;
    req.dir_z = 0;
    req.reach = 0;
    req.surface_height = 0;
    req.on_terrain = 1'b0;
    terrain_on = 1'b0;
    spacing = hrgp_pkg::SPACING_RESET;
    ray_phase = RAY_IDLE;
    quiet = 0;
    ready_hold = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_plane_ground();
    test_terrain_cases();
    test_march_limits();
    test_output_pressure();
    test_random_rays();
    wait_results_done();

    $display("Sent %0d requests and checked %0d results: %0d hits, %0d misses.",
             items, results, hits, misses);
    $display("Covered plane and terrain picks, bisection, edge cases and output back-pressure.");
    if (errors == 0 && pick_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
